// ===== sv/mcc_pkg.sv =====
// shared types, widths and helpers for the max convex crossing search block
package mcc_pkg;

    // largest graph the block can hold
    localparam int MAX_VERTS = 10;

    // fixed field widths of the channels
    localparam int FLD_W = 4;
    localparam int VC_W  = 4;
    localparam int OUT_W = 8;

    // derived widths
    localparam int IDX_W       = $clog2(MAX_VERTS);
    localparam int NV_W        = $clog2(MAX_VERTS + 1);
    localparam int PC_W        = $clog2(MAX_VERTS + 1);
    localparam int CROSS_BOUND = MAX_VERTS * (MAX_VERTS - 1) * (MAX_VERTS - 2)
                                 * (MAX_VERTS - 3) / 24;
    localparam int CROSS_W     = $clog2(CROSS_BOUND + 1);
    localparam int CNT_W       = (CROSS_W > OUT_W) ? CROSS_W : OUT_W;
    localparam int OUT_MAX     = (1 << OUT_W) - 1;
    localparam int MAX_RESULT  = (CROSS_BOUND > OUT_MAX) ? OUT_MAX : CROSS_BOUND;

    typedef logic [MAX_VERTS-1:0] t_row;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [PC_W-1:0]      t_pc;

    // command to the vertex order register file
    typedef struct packed {
        logic init;
        logic wr;
        t_idx waddr;
        t_idx wdata;
        t_idx raddr;
    } t_ord_cmd;

    // command to the adjacency store
    typedef struct packed {
        logic clr;
        logic wr;
        t_idx va;
        t_idx vb;
        t_idx raddr;
        t_row mask;
    } t_adj_cmd;

    // number of set bits in one adjacency row
    function automatic t_pc popcount(input t_row x);
        t_pc c;
        c = '0;
        for (int b = 0; b < MAX_VERTS; b++) begin
            c = c + t_pc'(x[b]);
        end
        return c;
    endfunction

endpackage

// ===== sv/mcc_if.sv =====
// valid/ready channel interfaces for edges, results and configuration
interface mcc_edge_if
    import mcc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [FLD_W-1:0] edge_from;
    logic [FLD_W-1:0] edge_to;
    logic             edge_present;
    logic             last_item;

    modport source (output valid, edge_from, edge_to, edge_present, last_item, input ready);
    modport sink   (input valid, edge_from, edge_to, edge_present, last_item, output ready);
endinterface

interface mcc_res_if
    import mcc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] max_crossings;

    modport source (output valid, max_crossings, input ready);
    modport sink   (input valid, max_crossings, output ready);
endinterface

interface mcc_cfg_if
    import mcc_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [VC_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

// ===== sv/mcc_adj.sv =====
// adjacency store: one row per vertex, edge writes, bulk clear, masked row popcount
module mcc_adj
    import mcc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_adj_cmd i_cmd,
    output t_row     o_row,
    output t_pc      o_pcnt
);

    t_row r_rows [MAX_VERTS];

    // edge write sets both symmetric bits, clear wipes the whole store
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < MAX_VERTS; r++) begin
            if (!i_rst_n || i_cmd.clr) begin
                r_rows[r] <= '0;
            end else if (i_cmd.wr) begin
                if (t_idx'(r) == i_cmd.va) begin
                    r_rows[r][i_cmd.vb] <= 1'b1;
                end
                if (t_idx'(r) == i_cmd.vb) begin
                    r_rows[r][i_cmd.va] <= 1'b1;
                end
            end
        end
    end

    // single read port and the crossing count contribution of that row
    assign o_row  = r_rows[i_cmd.raddr];
    assign o_pcnt = popcount(o_row & i_cmd.mask);

endmodule

// ===== sv/mcc_ord.sv =====
// vertex order register file: identity load, one write and one read port
module mcc_ord
    import mcc_pkg::*;
(
    input  logic     i_clk,
    input  t_ord_cmd i_cmd,
    output t_idx     o_rdata
);

    t_idx r_ord [MAX_VERTS];

    // identity load at search start, otherwise single entry write
    always_ff @(posedge i_clk) begin
        for (int p = 0; p < MAX_VERTS; p++) begin
            if (i_cmd.init) begin
                r_ord[p] <= t_idx'(p);
            end else if (i_cmd.wr && (i_cmd.waddr == t_idx'(p))) begin
                r_ord[p] <= i_cmd.wdata;
            end
        end
    end

    assign o_rdata = r_ord[i_cmd.raddr];

endmodule

// ===== sv/max_convex_crossing_search.sv =====
// top level: edge loading, permutation sequencer and crossing accumulator
//
// Usage: set vertex_count through the config channel while the block is idle,
// then send the edges of one graph on the edge channel, one beat each. Loading
// accepts one beat per cycle. The beat with last_item set starts the search and
// the edge channel stays not ready until the result has been handed to the
// output register.
// The search walks all (n-1)! orders of the first n-1 vertices with a Heap
// swap sequence; each step advances the Heap counters, clearing each counter
// that wraps, and then swaps two order entries. Every order goes through the
// mirror check; an order that passes is counted on one shared popcount and
// add unit, which visits each chord end, each chord start and each position
// lying strictly inside a chord. Fewer than four vertices gives 0.
// The result leaves through an output register, so a new graph can be
// loaded while a result still waits; a search that ends while that register
// is still full holds until the receiver takes the old result.
// Reset clears the adjacency store, vertex_count and the output valid flag.
// The adjacency store is cleared when the result is loaded for output.
module max_convex_crossing_search
    import mcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcc_cfg_if.sink     i_cfg,
    mcc_edge_if.sink    i_edge,
    mcc_res_if.source   o_res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK0 = 4'd1;
    localparam logic [3:0] S_CHK1 = 4'd2;
    localparam logic [3:0] S_LJ   = 4'd3;
    localparam logic [3:0] S_LI   = 4'd4;
    localparam logic [3:0] S_LK   = 4'd5;
    localparam logic [3:0] S_CMP  = 4'd6;
    localparam logic [3:0] S_HEAP = 4'd7;
    localparam logic [3:0] S_SW0  = 4'd8;
    localparam logic [3:0] S_SW1  = 4'd9;
    localparam logic [3:0] S_SW2  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]      r_state, n_state;
    logic [VC_W-1:0] r_vc;
    t_idx            r_m, n_m;
    t_idx            r_h, n_h;
    t_idx            r_i, n_i;
    t_idx            r_j, n_j;
    t_idx            r_k, n_k;
    t_idx            r_vj, n_vj;
    t_idx            r_t, n_t;
    t_idx            r_sa, n_sa;
    t_idx            r_sb, n_sb;
    t_row            r_after, n_after;
    t_cnt            r_cnt, n_cnt;
    t_cnt            r_best, n_best;
    t_idx            r_heapc [MAX_VERTS];
    t_idx            n_heapc [MAX_VERTS];
    logic            r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    t_ord_cmd  ord_cmd;
    t_adj_cmd  adj_cmd;
    t_idx      ord_rd;
    t_row      adj_row;
    t_pc       adj_pcnt;
    logic      in_beat;
    logic      edge_ok;
    logic [NV_W-1:0] n_eff;
    t_idx      i_inc;
    t_idx      k_inc;
    t_idx      h_cnt;
    t_row      vj_bit;

    mcc_ord u_ord (
        .i_clk   (i_clk),
        .i_cmd   (ord_cmd),
        .o_rdata (ord_rd)
    );

    mcc_adj u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (adj_cmd),
        .o_row   (adj_row),
        .o_pcnt  (adj_pcnt)
    );

    // handshakes
    assign i_cfg.ready         = 1'b1;
    assign i_edge.ready        = (r_state == S_IDLE);
    assign o_res.valid         = r_out_valid;
    assign o_res.max_crossings = r_out_data;
    assign in_beat             = i_edge.valid && (r_state == S_IDLE);

    // edge filter: no self loops, both ends inside the store
    assign edge_ok = i_edge.edge_present && (i_edge.edge_from != i_edge.edge_to)
                     && ({1'b0, i_edge.edge_from} < 5'(MAX_VERTS))
                     && ({1'b0, i_edge.edge_to} < 5'(MAX_VERTS));

    // effective vertex count, clamped to the store size
    assign n_eff = ({1'b0, r_vc} > 5'(MAX_VERTS)) ? NV_W'(MAX_VERTS) : NV_W'(r_vc);

    assign i_inc  = r_i + 1'b1;
    assign k_inc  = r_k + 1'b1;
    assign h_cnt  = r_heapc[r_h];
    assign vj_bit = t_row'(1) << r_vj;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_h         = r_h;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_vj        = r_vj;
        n_t         = r_t;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_after     = r_after;
        n_cnt       = r_cnt;
        n_best      = r_best;
        n_heapc     = r_heapc;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        ord_cmd       = '0;
        adj_cmd       = '0;
        adj_cmd.mask  = r_after;
        adj_cmd.va    = t_idx'(i_edge.edge_from);
        adj_cmd.vb    = t_idx'(i_edge.edge_to);
        adj_cmd.raddr = ord_rd;

        // output register drains on a taken beat
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    adj_cmd.wr = edge_ok;
                    if (i_edge.last_item) begin
                        n_best = '0;
                        if (n_eff < NV_W'(4)) begin
                            n_state = S_DONE;
                        end else begin
                            ord_cmd.init = 1'b1;
                            n_m          = t_idx'(n_eff - 1'b1);
                            n_h          = t_idx'(1);
                            for (int p = 0; p < MAX_VERTS; p++) begin
                                n_heapc[p] = '0;
                            end
                            n_state = S_CHK0;
                        end
                    end
                end
            end
            // mirror check: first position not above the last free position
            S_CHK0: begin
                ord_cmd.raddr = '0;
                n_t           = ord_rd;
                n_state       = S_CHK1;
            end
            S_CHK1: begin
                ord_cmd.raddr = r_m - 1'b1;
                if (r_t <= ord_rd) begin
                    n_j     = r_m;
                    n_after = '0;
                    n_cnt   = '0;
                    n_state = S_LJ;
                end else begin
                    n_state = S_HEAP;
                end
            end
            // outer loop over the chord end, from the last position down
            S_LJ: begin
                ord_cmd.raddr = r_j;
                n_vj          = ord_rd;
                n_i           = '0;
                n_state       = S_LI;
            end
            // chord start; sweep the inside positions only when an edge exists
            S_LI: begin
                ord_cmd.raddr = r_i;
                if (adj_row[r_vj] && (i_inc < r_j)) begin
                    n_k     = i_inc;
                    n_state = S_LK;
                end else if (i_inc == r_j) begin
                    n_after = r_after | vj_bit;
                    if (r_j == t_idx'(1)) begin
                        n_state = S_CMP;
                    end else begin
                        n_j     = r_j - 1'b1;
                        n_state = S_LJ;
                    end
                end else begin
                    n_i = i_inc;
                end
            end
            // inside position: add edges that reach past the chord end
            S_LK: begin
                ord_cmd.raddr = r_k;
                n_cnt         = r_cnt + t_cnt'(adj_pcnt);
                if (k_inc == r_j) begin
                    if (i_inc == r_j) begin
                        n_after = r_after | vj_bit;
                        n_state = S_CMP;
                    end else begin
                        n_i     = i_inc;
                        n_state = S_LI;
                    end
                end else begin
                    n_k = k_inc;
                end
            end
            S_CMP: begin
                if (r_cnt > r_best) begin
                    n_best = r_cnt;
                end
                n_state = S_HEAP;
            end
            // heap step: pick the next swap or finish the search
            S_HEAP: begin
                if (r_h == r_m) begin
                    n_state = S_DONE;
                end else if (h_cnt < r_h) begin
                    n_sa           = r_h[0] ? h_cnt : '0;
                    n_sb           = r_h;
                    n_heapc[r_h]   = h_cnt + 1'b1;
                    n_h            = t_idx'(1);
                    n_state        = S_SW0;
                end else begin
                    n_heapc[r_h] = '0;
                    n_h          = r_h + 1'b1;
                end
            end
            // swap two order entries in the states S_SW0, S_SW1 and S_SW2
            S_SW0: begin
                ord_cmd.raddr = r_sa;
                n_t           = ord_rd;
                n_state       = S_SW1;
            end
            S_SW1: begin
                ord_cmd.raddr = r_sb;
                ord_cmd.wr    = 1'b1;
                ord_cmd.waddr = r_sa;
                ord_cmd.wdata = ord_rd;
                n_state       = S_SW2;
            end
            S_SW2: begin
                ord_cmd.wr    = 1'b1;
                ord_cmd.waddr = r_sb;
                ord_cmd.wdata = r_t;
                n_state       = S_CHK0;
            end
            // hand the result to the output register and clear the store
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = (r_best > t_cnt'(OUT_MAX)) ? OUT_W'(OUT_MAX)
                                                             : r_best[OUT_W-1:0];
                    adj_cmd.clr = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_vc <= i_cfg.vertex_count;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_m        <= n_m;
        r_h        <= n_h;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_vj       <= n_vj;
        r_t        <= n_t;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_after    <= n_after;
        r_cnt      <= n_cnt;
        r_best     <= n_best;
        r_heapc    <= n_heapc;
        r_out_data <= n_out_data;
    end

endmodule

// ===== sv/mcc_chk.sv =====
// port level checks for the max convex crossing search block, bound to the top
module mcc_chk
    import mcc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_last,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] i_out_data
);

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // the last beat of a graph starts the search and closes the edge channel
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("edge channel still ready after last beat");

    // an ordinary edge beat keeps the channel open
    a_edge_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_last |=> i_in_ready)
        else $error("edge channel closed after a plain edge beat");

    // a new result appears only at the end of a search
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result raised while loading edges");

    // a convex drawing has at most one crossing per four vertices
    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data <= OUT_W'(MAX_RESULT)))
        else $error("crossing count above the bound");

endmodule

bind max_convex_crossing_search mcc_chk u_mcc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_edge.valid),
    .i_in_ready  (i_edge.ready),
    .i_in_last   (i_edge.last_item),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.max_crossings)
);

// ===== verif/tb_max_convex_crossing_search.sv =====
// testbench for max_convex_crossing_search: graph loads, crossing search results, config writes
`timescale 1ns / 100ps

module tb_max_convex_crossing_search;
    import mcc_pkg::*;

    localparam int LIMIT_CYCLES  = 20_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 50;
    localparam int RANDOM_BEATS  = 900;
    localparam int MAX_EDGES     = MAX_VERTS * (MAX_VERTS - 1) / 2;
    localparam int REPORT_LIMIT  = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mcc_cfg_if  cfg_if();
    mcc_edge_if edge_if();
    mcc_res_if  res_if();

    max_convex_crossing_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_edge  (edge_if),
        .o_res   (res_if)
    );

    // graph and register state as the block should hold it
    t_row             adj_rows [MAX_VERTS];
    logic [VC_W-1:0]  vcount_q;
    logic [OUT_W-1:0] pending_crossings [$];

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_left     = 0;
    int unsigned free_left      = 0;
    bit          send_burst     = 1'b0;

    // clock
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
    endtask

    // best crossing count over all circle orders, last vertex pinned at the end
    function automatic int unsigned predict_max_crossings();
        int unsigned n;
        int unsigned num_edges;
        int unsigned best;
        int unsigned total;
        int ea [MAX_EDGES];
        int eb [MAX_EDGES];
        int ord [MAX_VERTS];
        int pos [MAX_VERTS];
        int i, j, p, q, t;
        int lo1, hi1, lo2, hi2;
        bit more;
        n = (vcount_q > MAX_VERTS) ? MAX_VERTS : vcount_q;
        if (n < 4) return 0;
        // chords among the live vertices only
        num_edges = 0;
        for (i = 0; i < n; i++)
            for (j = i + 1; j < n; j++)
                if (adj_rows[i][j]) begin
                    ea[num_edges] = i;
                    eb[num_edges] = j;
                    num_edges++;
                end
        for (i = 0; i < n; i++) ord[i] = i;
        best = 0;
        more = 1'b1;
        while (more) begin
            for (i = 0; i < n; i++) pos[ord[i]] = i;
            // two chords cross when their endpoints interleave strictly
            total = 0;
            for (p = 0; p < num_edges; p++) begin
                lo1 = (pos[ea[p]] < pos[eb[p]]) ? pos[ea[p]] : pos[eb[p]];
                hi1 = (pos[ea[p]] < pos[eb[p]]) ? pos[eb[p]] : pos[ea[p]];
                for (q = p + 1; q < num_edges; q++) begin
                    lo2 = (pos[ea[q]] < pos[eb[q]]) ? pos[ea[q]] : pos[eb[q]];
                    hi2 = (pos[ea[q]] < pos[eb[q]]) ? pos[eb[q]] : pos[ea[q]];
                    if ((lo1 < lo2 && lo2 < hi1 && hi1 < hi2) ||
                        (lo2 < lo1 && lo1 < hi2 && hi2 < hi1))
                        total++;
                end
            end
            if (total > best) best = total;
            // step to the next order of positions 0..n-2
            i = n - 2;
            while (i > 0 && ord[i - 1] > ord[i]) i--;
            if (i == 0) begin
                more = 1'b0;
            end else begin
                j = n - 2;
                while (ord[j] < ord[i - 1]) j--;
                t = ord[i - 1];
                ord[i - 1] = ord[j];
                ord[j] = t;
                for (j = n - 2; i < j; i++, j--) begin
                    t = ord[i];
                    ord[i] = ord[j];
                    ord[j] = t;
                end
            end
        end
        return (best > OUT_MAX) ? OUT_MAX : best;
    endfunction

    // apply one accepted edge beat to the graph state
    task automatic take_edge(input logic [FLD_W-1:0] a, input logic [FLD_W-1:0] b,
                             input logic present, input logic last);
        if (present && a != b && a < MAX_VERTS && b < MAX_VERTS) begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
        end
        if (last) begin
            pending_crossings.push_back(OUT_W'(predict_max_crossings()));
            for (int v = 0; v < MAX_VERTS; v++) adj_rows[v] = '0;
        end
    endtask

    // one edge beat; entered and left at a falling edge, valid left high
    task automatic send_edge(input logic [FLD_W-1:0] a, input logic [FLD_W-1:0] b,
                             input logic present, input logic last);
        int unsigned gap;
        gap = send_burst ? 0 : pick_gap();
        if (gap != 0) begin
            edge_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        edge_if.valid        = 1'b1;
        edge_if.edge_from    = a;
        edge_if.edge_to      = b;
        edge_if.edge_present = present;
        edge_if.last_item    = last;
        do @(posedge i_clk); while (!edge_if.ready);
        @(negedge i_clk);
        take_edge(a, b, present, last);
    endtask

    // wait for all expected results, then let the block settle
    task automatic wait_drained();
        edge_if.valid = 1'b0;
        while (pending_crossings.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [VC_W-1:0] value);
        wait_drained();
        cfg_if.valid        = 1'b1;
        cfg_if.vertex_count = value;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
        vcount_q     = value;
    endtask

    // receiver stalls, with stall-free stretches now and then
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            res_if.ready = 1'b0;
            stall_left--;
        end else begin
            res_if.ready = 1'b1;
            if (free_left != 0)
                free_left--;
            else if ($urandom_range(3) == 0)
                stall_left = pick_gap();
            else if ($urandom_range(15) == 0)
                free_left = $urandom_range(20, 200);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_crossings.size() == 0)
                report_mismatch("max_crossings with nothing pending", -1,
                                res_if.max_crossings);
            else if (res_if.max_crossings !== pending_crossings[0])
                report_mismatch("max_crossings", pending_crossings.pop_front(),
                                res_if.max_crossings);
            else
                void'(pending_crossings.pop_front());
        end
    end

    // graphs too small to have a crossing, the reset register value and a four vertex graph
    task automatic test_tiny_graphs();
        send_edge(4'd1, 4'd2, 1'b1, 1'b1);
        write_vertex_count(4'd0);
        send_edge(4'd15, 4'd15, 1'b1, 1'b1);
        write_vertex_count(4'd3);
        send_edge(4'd0, 4'd1, 1'b1, 1'b0);
        send_edge(4'd1, 4'd2, 1'b1, 1'b0);
        send_edge(4'd2, 4'd0, 1'b1, 1'b1);
        write_vertex_count(4'd4);
        send_edge(4'd0, 4'd2, 1'b1, 1'b0);
        send_edge(4'd3, 4'd1, 1'b1, 1'b1);
    endtask

    // self-loops, out of range endpoints, empty beats, counts above the store size
    task automatic test_edge_special_cases();
        write_vertex_count(4'd10);
        send_edge(4'd9, 4'd8, 1'b1, 1'b0);
        send_edge(4'd15, 4'd0, 1'b1, 1'b0);
        send_edge(4'd10, 4'd11, 1'b1, 1'b0);
        write_vertex_count(4'd15);
        send_edge(4'd4, 4'd4, 1'b1, 1'b0);
        send_edge(4'd6, 4'd3, 1'b0, 1'b0);
        send_edge(4'd4, 4'd9, 1'b1, 1'b0);
        // edges stored above vertex_count must not count
        write_vertex_count(4'd5);
        send_edge(4'd0, 4'd2, 1'b1, 1'b0);
        send_edge(4'd1, 4'd3, 1'b1, 1'b0);
        send_edge(4'd1, 4'd4, 1'b1, 1'b1);
        // next graph right behind, result may still sit in the output register
        send_edge(4'd0, 4'd3, 1'b1, 1'b0);
        send_edge(4'd2, 4'd4, 1'b1, 1'b1);
    endtask

    // random graphs, mostly well-formed edges among the live vertices
    task automatic test_random_graphs();
        int unsigned beats;
        int unsigned len;
        int unsigned r;
        int unsigned x;
        int unsigned y;
        logic [FLD_W-1:0] a;
        logic [FLD_W-1:0] b;
        logic present;
        bit first;
        beats = 0;
        first = 1'b1;
        while (beats < RANDOM_BEATS) begin
            // new vertex count between graphs, small sizes keep the search short
            if (first || $urandom_range(1) == 0) begin
                r = $urandom_range(99);
                if (r < 5)       x = $urandom_range(0, 3);
                else if (r < 20) x = 4;
                else if (r < 50) x = 5;
                else if (r < 95) x = 6;
                else             x = 7;
                write_vertex_count(VC_W'(x));
                first = 1'b0;
            end
            send_burst = ($urandom_range(3) == 0);
            len = ($urandom_range(9) < 7) ? $urandom_range(1, 10) : $urandom_range(11, 24);
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(99);
                if (r < 80 && vcount_q >= 2) begin
                    x = $urandom_range(vcount_q - 1);
                    y = (x + 1 + $urandom_range(vcount_q - 2)) % vcount_q;
                end else if (r < 88) begin
                    x = $urandom_range(15);
                    y = x;
                end else begin
                    x = $urandom_range(15);
                    y = $urandom_range(15);
                end
                a = FLD_W'(x);
                b = FLD_W'(y);
                present = ($urandom_range(9) != 0);
                send_edge(a, b, present, k == len - 1);
                beats++;
            end
        end
        send_burst = 1'b0;
    endtask

    initial begin
        i_rst_n              = 1'b0;
        edge_if.valid        = 1'b0;
        edge_if.edge_from    = '0;
        edge_if.edge_to      = '0;
        edge_if.edge_present = 1'b0;
        edge_if.last_item    = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.vertex_count  = '0;
        vcount_q             = '0;
        for (int v = 0; v < MAX_VERTS; v++) adj_rows[v] = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_tiny_graphs();
        test_edge_special_cases();
        test_random_graphs();

        // drain and check that nothing is left over
        edge_if.valid = 1'b0;
        while (pending_crossings.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatch_count == 0 && pending_crossings.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
